// File: sv/pfa_pkg.sv
`timescale 1ns / 1ps

package pfa_pkg;

  // payload widths fixed by the item format
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CNT_OUT_W = 11;
  localparam int unsigned CFG_IDX_W = 1;

  // register reset values
  localparam logic [CFG_W-1:0] TOTAL_PAGES_RST    = 11'd1024;
  localparam logic [CFG_W-1:0] RESERVED_PAGES_RST = 11'd0;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PAGES    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_PAGES = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } pfa_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_OUT_OF_RANGE = 2'd2,
    ST_NOT_ALLOC    = 2'd3
  } pfa_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INIT,
    S_EXEC
  } pfa_state_e;

endpackage

// File: sv/pfa_if.sv
`timescale 1ns / 1ps

// command channel
interface pfa_req_if import pfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] page_address;

  modport source (output valid, cmd, page_address, input ready);
  modport sink   (input valid, cmd, page_address, output ready);
endinterface

// result channel
interface pfa_rsp_if import pfa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ADDR_W-1:0]    alloc_address;
  logic [STATUS_W-1:0]  status;
  logic [CNT_OUT_W-1:0] free_count;

  modport source (output valid, alloc_address, status, free_count, input ready);
  modport sink   (input valid, alloc_address, status, free_count, output ready);
endinterface

// register write channel
interface pfa_cfg_if import pfa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/pfa_ram.sv
`timescale 1ns / 1ps

module pfa_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 10,
  parameter int unsigned AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/page_frame_allocator_core.sv
`timescale 1ns / 1ps

// Page frame allocator with a first-in first-out free list held in a one-read,
// one-write queue memory, and the per-page allocated marks in a second memory.
// Allocate and free accept the item and issue the memory read, then, once the
// result slot is free, modify, write back and load the result register. Init
// sweeps pages 0 .. limit-1 one per cycle, writing each page's mark and, for
// pages above the reserved ones, its queue slot. No item is accepted while an
// item is in work. Memory words at or above the latched limit are never used,
// so the memories need no clearing pass after reset; before the first init an
// allocate answers "no free page" and a free answers "out of range".
module page_frame_allocator_core import pfa_pkg::*; #(
  parameter int unsigned MAX_PAGES  = 1024,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfa_req_if.sink   req_i,
  pfa_rsp_if.source rsp_o,
  pfa_cfg_if.sink   cfg_i
);

  localparam int unsigned PW = $clog2(MAX_PAGES);
  localparam int unsigned CW = $clog2(MAX_PAGES + 1);
  localparam logic [PW-1:0]     LAST_POS = PW'(MAX_PAGES - 1);
  localparam logic [ADDR_W-1:0] MAX32    = ADDR_W'(MAX_PAGES);

  function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] pos);
    return (pos == LAST_POS) ? '0 : pos + PW'(1);
  endfunction

  pfa_state_e state_q, state_d;

  logic [CFG_W-1:0] total_q, reserved_q;
  logic [CW-1:0]    limit_q, limit_d;
  logic [CW-1:0]    resv_q, resv_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [PW-1:0]    head_q, head_d;
  logic [PW-1:0]    tail_q, tail_d;
  logic [CMD_W-1:0] cmd_q;
  logic [ADDR_W-1:0] page_q, page_w;

  logic                 out_valid_q;
  logic [ADDR_W-1:0]    out_addr_q, out_addr_d;
  logic [STATUS_W-1:0]  out_status_q, out_status_d;
  logic [CNT_OUT_W-1:0] out_cnt_q;
  logic [CW+CNT_OUT_W-1:0] cnt_ext;
  logic                 out_load;
  logic                 slot_free;
  logic                 accept;

  logic [CW-1:0] lim_w, resv_w, qn_w;
  logic [PW-1:0] tail_init;

  logic          q_we, q_re;
  logic [PW-1:0] q_waddr, q_wdata, q_rdata;
  logic          m_we, m_re;
  logic [PW-1:0] m_waddr;
  logic [0:0]    m_wdata, m_rdata;

  assign accept    = req_i.valid && req_i.ready;
  assign slot_free = !out_valid_q || rsp_o.ready;
  assign page_w    = req_i.page_address >> PAGE_SHIFT;

  // register port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= TOTAL_PAGES_RST;
      reserved_q <= RESERVED_PAGES_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_TOTAL_PAGES:    total_q    <= cfg_i.data;
        REG_RESERVED_PAGES: reserved_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // init bounds: saturate page count and reserved count
  always_comb begin
    lim_w  = (ADDR_W'(total_q) > MAX32) ? CW'(MAX_PAGES) : CW'(total_q);
    resv_w = (ADDR_W'(reserved_q) > ADDR_W'(lim_w)) ? lim_w : CW'(reserved_q);
    qn_w   = lim_w - resv_w;
    tail_init = (ADDR_W'(qn_w) == MAX32) ? '0 : qn_w[PW-1:0];
  end

  // free queue and allocated marks
  pfa_ram #(.DEPTH(MAX_PAGES), .WIDTH(PW), .AW(PW)) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (head_q),
    .rdata_o (q_rdata)
  );

  pfa_ram #(.DEPTH(MAX_PAGES), .WIDTH(1), .AW(PW)) u_mark (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .re_i    (m_re),
    .raddr_i (page_w[PW-1:0]),
    .rdata_o (m_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (req_i.cmd == CMD_INIT) ? S_INIT : S_EXEC;
        end
      end
      S_INIT: begin
        if (idx_q == limit_q && slot_free) state_d = S_IDLE;
      end
      S_EXEC: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_i.ready  = (state_q == S_IDLE);
    q_re         = accept && (req_i.cmd == CMD_ALLOC);
    m_re         = accept && (req_i.cmd == CMD_FREE);
    q_we         = 1'b0;
    q_waddr      = tail_q;
    q_wdata      = page_q[PW-1:0];
    m_we         = 1'b0;
    m_waddr      = page_q[PW-1:0];
    m_wdata      = 1'b0;
    limit_d      = limit_q;
    resv_d       = resv_q;
    count_d      = count_q;
    idx_d        = idx_q;
    head_d       = head_q;
    tail_d       = tail_q;
    out_load     = 1'b0;
    out_addr_d   = '0;
    out_status_d = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (accept && req_i.cmd == CMD_INIT) begin
          limit_d = lim_w;
          resv_d  = resv_w;
          count_d = qn_w;
          idx_d   = '0;
          head_d  = '0;
          tail_d  = tail_init;
        end
      end
      S_INIT: begin
        // one page per cycle: mark kernel pages, queue the rest in order
        if (idx_q != limit_q) begin
          m_we    = 1'b1;
          m_waddr = idx_q[PW-1:0];
          m_wdata = (idx_q < resv_q);
          q_we    = (idx_q >= resv_q);
          q_waddr = PW'(idx_q - resv_q);
          q_wdata = idx_q[PW-1:0];
          idx_d   = idx_q + CW'(1);
        end else begin
          out_load = slot_free;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          out_load = 1'b1;
          case (pfa_cmd_e'(cmd_q))
            CMD_ALLOC: begin
              if (count_q == '0) begin
                out_status_d = ST_NO_FREE;
              end else begin
                m_we       = 1'b1;
                m_waddr    = q_rdata;
                m_wdata    = 1'b1;
                head_d     = wrap_next(head_q);
                count_d    = count_q - CW'(1);
                out_addr_d = ADDR_W'(q_rdata) << PAGE_SHIFT;
              end
            end
            CMD_FREE: begin
              if (page_q >= ADDR_W'(limit_q)) begin
                out_status_d = ST_OUT_OF_RANGE;
              end else if (!m_rdata[0]) begin
                out_status_d = ST_NOT_ALLOC;
              end else begin
                m_we    = 1'b1;
                q_we    = 1'b1;
                tail_d  = wrap_next(tail_q);
                count_d = count_q + CW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    cnt_ext = {{CNT_OUT_W{1'b0}}, count_d};
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= '0;
      resv_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      limit_q <= limit_d;
      resv_q  <= resv_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item capture and result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= req_i.cmd;
      page_q <= page_w;
    end
    if (out_load) begin
      out_addr_q   <= out_addr_d;
      out_status_q <= out_status_d;
      out_cnt_q    <= cnt_ext[CNT_OUT_W-1:0];
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.alloc_address = out_addr_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.free_count    = out_cnt_q;

`ifndef SYNTHESIS
  // the free list never holds more pages than were latched at init
  a_count_le_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= limit_q)
    else $error("free count exceeds page limit");

  // an empty list has its pointers together
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("empty free list with head and tail apart");

  // the init sweep stays inside the latched page range
  a_sweep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> (idx_q <= limit_q && resv_q <= limit_q))
    else $error("init sweep beyond page limit");

  // a result is loaded only when the slot is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |-> !out_load)
    else $error("result overwritten before it was taken");
`endif

endmodule
